// ----- rtl/audio_stream_interface_regs_defines.svh -----
// ----------------------------------------------------------------------------
// Audio stream interface register block: assertion macros
// Shared helpers for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef AUDIO_STREAM_INTERFACE_REGS_DEFINES_SVH
`define AUDIO_STREAM_INTERFACE_REGS_DEFINES_SVH

// check that is switched off while reset is held
`define ASIR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define ASIR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/asir_pkg.sv -----
// ----------------------------------------------------------------------------
// Audio stream interface register block: package
// Word types, command and address codes, control bit positions.
// ----------------------------------------------------------------------------
package asir_pkg;

    // commands
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_SAMPLE = 2'd3;

    // register addresses (low 16 bits)
    localparam logic [15:0] ADDR_CONTROL = 16'h6C00;
    localparam logic [15:0] ADDR_VOLUME  = 16'h6C04;
    localparam logic [15:0] ADDR_COUNTER = 16'h6C08;
    localparam logic [15:0] ADDR_TIMING  = 16'h6C0C;

    // control word bit positions
    localparam int CTRL_PLAY     = 0;
    localparam int CTRL_RATE     = 1;
    localparam int CTRL_MASK     = 2;
    localparam int CTRL_STATUS   = 3;
    localparam int CTRL_CMP_EN   = 4;
    localparam int CTRL_CNT_RST  = 5;
    localparam int CTRL_DSP_RATE = 6;

    // configuration register indexes
    localparam logic CFG_RATE_SET   = 1'b0;
    localparam logic CFG_RATE_CLEAR = 1'b1;

    // ticks per sample after reset: 32 kHz and 48 kHz
    localparam logic [15:0] RATE_SET_RESET   = 16'd15187;
    localparam logic [15:0] RATE_CLEAR_RESET = 16'd10125;

    localparam int PHASE_W  = 17;
    localparam int PERIOD_W = 16;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        reg_offset;
        logic [31:0]        write_data;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } t_in_word;

    typedef struct packed {
        logic [31:0]        read_data;
        logic               irq_line;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_out_word;

endpackage

// ----- rtl/audio_stream_interface_regs.sv -----
// ----------------------------------------------------------------------------
// Audio stream interface register block
// Control, volume, sample counter and interrupt timing registers, tick
// driven sample counter with compare interrupt, and stereo volume scaling.
// ----------------------------------------------------------------------------
// Words pass through an input register and a result register, so a word is
// accepted every cycle while the output is not stalled, and with no stall its
// result is valid from the clock edge after it is accepted. One case is slower.
// A tick can find the phase two or more sample periods ahead, which only
// happens after the period was shortened while playing. That tick holds the
// input register while a one-bit-per-cycle divider works out how many periods
// have gone by. The configuration port is always ready.
module audio_stream_interface_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  asir_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output asir_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import asir_pkg::*;

    localparam logic [1:0] DIV_IDLE = 2'd0;
    localparam logic [1:0] DIV_RUN  = 2'd1;
    localparam logic [1:0] DIV_DONE = 2'd2;
    localparam int         CNT_W    = $clog2(PHASE_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PHASE_W - 1);

    // pipeline registers
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    // block state
    logic                r_play, n_play;
    logic                r_rate, n_rate;
    logic                r_mask, n_mask;
    logic                r_status, n_status;
    logic                r_cmp_en, n_cmp_en;
    logic                r_dsp_rate, n_dsp_rate;
    logic [31:0]         r_volume, n_volume;
    logic [31:0]         r_count, n_count;
    logic [31:0]         r_threshold, n_threshold;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic                r_period_valid, n_period_valid;
    logic [PERIOD_W-1:0] r_cfg_set;
    logic [PERIOD_W-1:0] r_cfg_clear;

    // divider
    logic [1:0]          r_div_state;
    logic [CNT_W-1:0]    r_div_cnt;
    logic [PERIOD_W-1:0] r_div_rem;
    logic [PHASE_W-1:0]  r_div_quo;

    t_out_word           n_out;
    logic                out_free;
    logic                step_go;
    logic                tick_run;
    logic [PERIOD_W-1:0] per_eff;
    logic [PHASE_W-1:0]  per_ext;
    logic [PHASE_W-1:0]  phase_inc;
    logic                over;
    logic [PHASE_W-1:0]  diff;
    logic                need_div;
    logic [PHASE_W-1:0]  adv_n;
    logic [PHASE_W-1:0]  new_phase;
    logic [31:0]         count_adv;
    logic [PHASE_W-1:0]  rem_sh;
    logic                rem_ge;
    logic [PHASE_W-1:0]  rem_sub;
    logic signed [24:0]  prod_l;
    logic signed [24:0]  prod_r;
    logic [31:0]         wd;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign out_free = !r_out_valid || i_out_ready;
    assign wd       = r_in.write_data;

    // tick arithmetic
    assign tick_run  = (r_in.cmd == CMD_TICK) && r_play && r_period_valid;
    assign per_eff   = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign per_ext   = {1'b0, per_eff};
    assign phase_inc = r_phase + PHASE_W'(1);
    assign over      = phase_inc > per_ext;
    assign diff      = phase_inc - per_ext;
    assign need_div  = tick_run && over && (diff >= per_ext);
    assign adv_n     = need_div ? r_div_quo : PHASE_W'(1);
    assign new_phase = need_div ? {1'b0, r_div_rem} : diff;
    assign count_adv = r_count + {{(32-PHASE_W){1'b0}}, adv_n};

    assign step_go    = r_in_valid && out_free && (!need_div || (r_div_state == DIV_DONE));
    assign o_in_ready = !r_in_valid || step_go;

    // one restoring division step
    assign rem_sh  = {r_div_rem, r_div_quo[PHASE_W-1]};
    assign rem_ge  = rem_sh >= per_ext;
    assign rem_sub = rem_sh - per_ext;

    // volume scaling, floor of product over 256
    assign prod_l = r_in.left_in * $signed({1'b0, r_volume[7:0]});
    assign prod_r = r_in.right_in * $signed({1'b0, r_volume[15:8]});

    always_comb begin
        n_play         = r_play;
        n_rate         = r_rate;
        n_mask         = r_mask;
        n_status       = r_status;
        n_cmp_en       = r_cmp_en;
        n_dsp_rate     = r_dsp_rate;
        n_volume       = r_volume;
        n_count        = r_count;
        n_threshold    = r_threshold;
        n_phase        = r_phase;
        n_period       = r_period;
        n_period_valid = r_period_valid;
        n_out          = '0;
        case (r_in.cmd)
            CMD_READ: begin
                case (r_in.reg_offset)
                    ADDR_CONTROL: begin
                        n_out.read_data[CTRL_PLAY]     = r_play;
                        n_out.read_data[CTRL_RATE]     = r_rate;
                        n_out.read_data[CTRL_MASK]     = r_mask;
                        n_out.read_data[CTRL_STATUS]   = r_status;
                        n_out.read_data[CTRL_CMP_EN]   = r_cmp_en;
                        n_out.read_data[CTRL_DSP_RATE] = r_dsp_rate;
                    end
                    ADDR_VOLUME:  n_out.read_data = r_volume;
                    ADDR_COUNTER: begin
                        n_out.read_data = r_count;
                        // post-increment while playing, no compare
                        if (r_play) begin
                            n_count = r_count + 32'd1;
                        end
                    end
                    ADDR_TIMING:  n_out.read_data = r_threshold;
                    default: ;
                endcase
            end
            CMD_WRITE: begin
                case (r_in.reg_offset)
                    ADDR_CONTROL: begin
                        n_mask         = wd[CTRL_MASK];
                        n_cmp_en       = wd[CTRL_CMP_EN];
                        n_rate         = wd[CTRL_RATE];
                        n_dsp_rate     = wd[CTRL_DSP_RATE];
                        n_period       = wd[CTRL_RATE] ? r_cfg_set : r_cfg_clear;
                        n_period_valid = 1'b1;
                        if (wd[CTRL_PLAY] != r_play) begin
                            n_play  = wd[CTRL_PLAY];
                            n_phase = '0;
                        end
                        if (wd[CTRL_STATUS]) begin
                            n_status = 1'b0;
                        end
                        if (wd[CTRL_CNT_RST]) begin
                            n_count = '0;
                            n_phase = '0;
                        end
                    end
                    ADDR_VOLUME:  n_volume    = wd;
                    ADDR_COUNTER: n_count     = wd;
                    ADDR_TIMING:  n_threshold = wd;
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (tick_run) begin
                    n_phase = phase_inc;
                    if (over) begin
                        n_phase = new_phase;
                        n_count = count_adv;
                        if (r_cmp_en && (count_adv >= r_threshold)) begin
                            n_status = 1'b1;
                        end
                    end
                end
            end
            CMD_SAMPLE: begin
                if (r_play) begin
                    n_out.left_out  = prod_l[23:8];
                    n_out.right_out = prod_r[23:8];
                end
            end
            default: ;
        endcase
        n_out.irq_line = n_status & n_mask;
    end

    // control and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_div_state    <= DIV_IDLE;
            r_play         <= 1'b0;
            r_rate         <= 1'b1;
            r_mask         <= 1'b0;
            r_status       <= 1'b0;
            r_cmp_en       <= 1'b0;
            r_dsp_rate     <= 1'b0;
            r_volume       <= '0;
            r_count        <= '0;
            r_threshold    <= '0;
            r_phase        <= '0;
            r_period       <= '0;
            r_period_valid <= 1'b0;
            r_cfg_set      <= RATE_SET_RESET;
            r_cfg_clear    <= RATE_CLEAR_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (step_go) begin
                r_play         <= n_play;
                r_rate         <= n_rate;
                r_mask         <= n_mask;
                r_status       <= n_status;
                r_cmp_en       <= n_cmp_en;
                r_dsp_rate     <= n_dsp_rate;
                r_volume       <= n_volume;
                r_count        <= n_count;
                r_threshold    <= n_threshold;
                r_phase        <= n_phase;
                r_period       <= n_period;
                r_period_valid <= n_period_valid;
            end
            case (r_div_state)
                DIV_IDLE: begin
                    if (r_in_valid && need_div) begin
                        r_div_state <= DIV_RUN;
                    end
                end
                DIV_RUN: begin
                    if (r_div_cnt == '0) begin
                        r_div_state <= DIV_DONE;
                    end
                end
                DIV_DONE: begin
                    if (step_go) begin
                        r_div_state <= DIV_IDLE;
                    end
                end
                default: r_div_state <= DIV_IDLE;
            endcase
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RATE_SET:   r_cfg_set   <= i_cfg_data;
                    CFG_RATE_CLEAR: r_cfg_clear <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload and divider datapath
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
        if (step_go) begin
            r_out <= n_out;
        end
        if (r_div_state == DIV_IDLE) begin
            r_div_quo <= phase_inc;
            r_div_rem <= '0;
            r_div_cnt <= DIV_LAST;
        end else if (r_div_state == DIV_RUN) begin
            r_div_rem <= rem_ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
            r_div_quo <= {r_div_quo[PHASE_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt - CNT_W'(1);
        end
    end

endmodule

// ----- rtl/asir_checker.sv -----
// ----------------------------------------------------------------------------
// Audio stream interface register block: port checker
// Watches the top level's ports for invented, unstable or too many words.
// ----------------------------------------------------------------------------
`include "audio_stream_interface_regs_defines.svh"

module asir_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input asir_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input asir_pkg::t_out_word o_out_word,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic                i_cfg_index,
    input logic [15:0]         i_cfg_data
);
    import asir_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // words taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_pending <= r_pending + 2'd1;
                2'b01:   r_pending <= r_pending - 2'd1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    `ASIR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word), "result word changed while stalled")
    `ASIR_ASSERT(a_no_invented, i_clk, i_rst_n, out_acc |-> r_pending != 2'd0, "result word with no word taken in")
    `ASIR_ASSERT(a_depth, i_clk, i_rst_n, r_pending != 2'd3, "more words in flight than the block holds")
    `ASIR_ASSERT_RST(a_rst_idle, i_clk, !i_rst_n |=> !o_out_valid, "result valid straight after reset")

endmodule

bind audio_stream_interface_regs asir_checker u_asir_checker (.*);
